// ----- rtl/core/unique_key_stack_unit_defines.svh -----
// Assertion macros used by the unique key stack controller.
`ifndef UNIQUE_KEY_STACK_UNIT_DEFINES_SVH
`define UNIQUE_KEY_STACK_UNIT_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define UKS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define UKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/core/uks_pkg.sv -----
// Shared types and constants for the unique key stack.
`default_nettype none

package uks_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 5;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED    = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_POPPED    = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POP_RD,
    S_DECIDE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan;
    logic pop_rd;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_pop;
    logic count_zero;
    logic scan_done;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/uks_req_if.sv -----
// Request channel: command with key and value.
`default_nettype none

interface uks_req_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic signed [uks_pkg::KEY_W-1:0]   in_key;
  logic signed [uks_pkg::VALUE_W-1:0] in_value;

  modport source (output valid, output cmd, output in_key, output in_value, input ready);
  modport sink   (input valid, input cmd, input in_key, input in_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/uks_rsp_if.sv -----
// Response channel: status, popped pair and fill count.
`default_nettype none

interface uks_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [uks_pkg::STATUS_W-1:0]       status;
  logic signed [uks_pkg::KEY_W-1:0]   out_key;
  logic signed [uks_pkg::VALUE_W-1:0] out_value;
  logic [uks_pkg::FILL_W-1:0]         fill_count;

  modport source (output valid, output status, output out_key, output out_value,
                  output fill_count, input ready);
  modport sink   (input valid, input status, input out_key, input out_value,
                  input fill_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/unique_key_stack_unit.sv -----
// Top level of the unique key stack: LIFO of key/value pairs with duplicate check.
// A push runs accept, a scan of the stored keys at one key per cycle through the single memory
// read port until the last read has drained, then commit; a push to an empty stack skips the
// scan. A pop runs accept, top read, commit. Commit waits until the output register is free.
// One transaction is in flight; the next accept comes the cycle after commit, and a new request
// is accepted while the previous response still waits in the output register.
// Synchronous active-high reset empties the stack and drops any pending response.
`default_nettype none

module unique_key_stack_unit #(
  parameter int STACK_DEPTH = uks_pkg::STACK_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  uks_req_if.sink   req,
  uks_rsp_if.source rsp
);

  uks_pkg::ctrl_cmd_t cmd;
  uks_pkg::ctrl_sts_t sts;

  uks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd_out   (cmd),
    .sts       (sts)
  );

  uks_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd_in     (cmd),
    .sts        (sts),
    .req_cmd    (req.cmd),
    .req_key    (req.in_key),
    .req_value  (req.in_value),
    .status     (rsp.status),
    .out_key    (rsp.out_key),
    .out_value  (rsp.out_value),
    .fill_count (rsp.fill_count)
  );

endmodule

`default_nettype wire

// ----- rtl/core/uks_datapath.sv -----
// Stack storage, key scan and result register of the unique key stack.
`default_nettype none

module uks_datapath #(
  parameter int STACK_DEPTH = uks_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire uks_pkg::ctrl_cmd_t                 cmd_in,
  output      uks_pkg::ctrl_sts_t                 sts,
  input  wire logic                               req_cmd,
  input  wire logic [uks_pkg::KEY_W-1:0]          req_key,
  input  wire logic [uks_pkg::VALUE_W-1:0]        req_value,
  output      logic [uks_pkg::STATUS_W-1:0]       status,
  output      logic [uks_pkg::KEY_W-1:0]          out_key,
  output      logic [uks_pkg::VALUE_W-1:0]        out_value,
  output      logic [uks_pkg::FILL_W-1:0]         fill_count
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  logic [uks_pkg::KEY_W-1:0]   key_mem [STACK_DEPTH];
  logic [uks_pkg::VALUE_W-1:0] value_mem [STACK_DEPTH];

  logic                        op;
  logic [uks_pkg::KEY_W-1:0]   key_r;
  logic [uks_pkg::VALUE_W-1:0] value_r;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;
  logic [CNT_W-1:0]            idx;
  logic                        hit;
  logic                        rd_vld;
  logic [uks_pkg::KEY_W-1:0]   rd_key;
  logic [uks_pkg::VALUE_W-1:0] rd_value;

  logic                        issue_done;
  logic                        rd_en;
  logic [ADDR_W-1:0]           rd_addr;
  logic                        wr_en;
  logic [CNT_W-1:0]            count_dec;
  logic [CNT_W+uks_pkg::FILL_W-1:0] fill_wide;

  uks_pkg::status_t            res_status;
  logic [uks_pkg::KEY_W-1:0]   res_key;
  logic [uks_pkg::VALUE_W-1:0] res_value;

  // Status toward the controller
  assign issue_done     = (idx == count);
  assign sts.req_pop    = (req_cmd == uks_pkg::CMD_POP);
  assign sts.count_zero = (count == '0);
  assign sts.scan_done  = issue_done && !rd_vld;

  // Select the read address: scan index or top entry
  assign count_dec = count - CNT_W'(1);
  assign rd_en     = (cmd_in.scan && !issue_done) || (cmd_in.pop_rd && count != '0);
  assign rd_addr   = cmd_in.pop_rd ? count_dec[ADDR_W-1:0] : idx[ADDR_W-1:0];

  // Latch the request and run the scan index
  always_ff @(posedge clk) begin
    if (cmd_in.accept) begin
      op      <= req_cmd;
      key_r   <= req_key;
      value_r <= req_value;
      idx     <= '0;
      hit     <= 1'b0;
    end else if (cmd_in.scan) begin
      if (!issue_done) begin
        idx <= idx + CNT_W'(1);
      end
      if (rd_vld && rd_key == key_r) begin
        hit <= 1'b1;
      end
    end
  end

  // Track the read in flight during the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd_in.scan && !issue_done;
    end
  end

  // Storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[count[ADDR_W-1:0]]   <= key_r;
      value_mem[count[ADDR_W-1:0]] <= value_r;
    end
    if (rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
    end
  end

  // Decide the outcome of the transaction
  always_comb begin
    res_status = uks_pkg::ST_PUSHED;
    res_key    = '0;
    res_value  = '0;
    count_next = count;
    wr_en      = 1'b0;
    if (op == uks_pkg::CMD_POP) begin
      if (count == '0) begin
        res_status = uks_pkg::ST_UNDERFLOW;
      end else begin
        res_status = uks_pkg::ST_POPPED;
        res_key    = rd_key;
        res_value  = rd_value;
        count_next = count_dec;
      end
    end else if (hit) begin
      res_status = uks_pkg::ST_DUPLICATE;
    end else if (count == CNT_W'(STACK_DEPTH)) begin
      res_status = uks_pkg::ST_OVERFLOW;
    end else begin
      res_status = uks_pkg::ST_PUSHED;
      count_next = count + CNT_W'(1);
      wr_en      = cmd_in.commit;
    end
  end

  // Update the fill count on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd_in.commit) begin
      count <= count_next;
    end
  end

  // Load the result register on commit
  assign fill_wide = {{uks_pkg::FILL_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (cmd_in.commit) begin
      status     <= res_status;
      out_key    <= res_key;
      out_value  <= res_value;
      fill_count <= fill_wide[uks_pkg::FILL_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/uks_ctrl.sv -----
// Controller state machine of the unique key stack.
`default_nettype none
`include "unique_key_stack_unit_defines.svh"

module uks_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output      logic               req_ready,
  output      logic               rsp_valid,
  input  wire logic               rsp_ready,
  output      uks_pkg::ctrl_cmd_t cmd_out,
  input  wire uks_pkg::ctrl_sts_t sts
);

  uks_pkg::state_t state;
  uks_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !rsp_valid || rsp_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uks_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      uks_pkg::S_IDLE: begin
        if (req_valid) begin
          if (sts.req_pop) begin
            state_next = uks_pkg::S_POP_RD;
          end else if (sts.count_zero) begin
            state_next = uks_pkg::S_DECIDE;
          end else begin
            state_next = uks_pkg::S_SCAN;
          end
        end
      end
      uks_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          state_next = uks_pkg::S_DECIDE;
        end
      end
      uks_pkg::S_POP_RD: begin
        state_next = uks_pkg::S_DECIDE;
      end
      uks_pkg::S_DECIDE: begin
        if (out_free) begin
          state_next = uks_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = uks_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    req_ready      = 1'b0;
    cmd_out        = '0;
    case (state)
      uks_pkg::S_IDLE: begin
        req_ready      = 1'b1;
        cmd_out.accept = req_valid;
      end
      uks_pkg::S_SCAN: begin
        cmd_out.scan = 1'b1;
      end
      uks_pkg::S_POP_RD: begin
        cmd_out.pop_rd = 1'b1;
      end
      uks_pkg::S_DECIDE: begin
        cmd_out.commit = out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // Hold the response valid until taken; set on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd_out.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  `UKS_ASSERT_SAME(a_commit_room, clk, rst, cmd_out.commit, !rsp_valid || rsp_ready)
  `UKS_ASSERT_NEXT(a_accept_busy, clk, rst, cmd_out.accept, state != uks_pkg::S_IDLE)
  `UKS_ASSERT_NEXT(a_scan_end, clk, rst, state == uks_pkg::S_SCAN && sts.scan_done, state == uks_pkg::S_DECIDE)
  `UKS_ASSERT_NEXT(a_commit_resp, clk, rst, cmd_out.commit, rsp_valid && state == uks_pkg::S_IDLE)

endmodule

`default_nettype wire

// ----- tb/sv/uks_stack_monitor.sv -----
// Channel monitor for the unique key stack: predicts each response and compares it.
`timescale 1ns / 100ps

module uks_stack_monitor #(
  parameter int STACK_DEPTH = uks_pkg::STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  uks_req_if        req,
  uks_rsp_if        rsp,
  output int        fail_count,
  output int        replies_due
);
  import uks_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    status_t              status;
    logic [KEY_W-1:0]     key;
    logic [VALUE_W-1:0]   value;
    logic [FILL_W-1:0]    fill;
  } stack_reply_t;

  // Shadow copy of the stack contents and its fill level
  logic [KEY_W-1:0]   key_mem   [STACK_DEPTH];
  logic [VALUE_W-1:0] value_mem [STACK_DEPTH];
  int                 depth_used;

  stack_reply_t reply_q[$];
  int           mismatch_total;

  assign fail_count = mismatch_total;

  // Apply one request to the shadow stack and return the response it must produce
  function automatic stack_reply_t predict_stack_reply(logic op, logic [KEY_W-1:0] k,
                                                       logic [VALUE_W-1:0] v);
    stack_reply_t r;
    bit           dup;
    r.key   = '0;
    r.value = '0;
    dup     = 1'b0;
    if (op == CMD_PUSH) begin
      // duplicate search covers only live entries and wins over the room check
      for (int i = 0; i < depth_used; i++) begin
        if (key_mem[i] == k) dup = 1'b1;
      end
      if (dup) begin
        r.status = ST_DUPLICATE;
      end else if (depth_used >= STACK_DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        key_mem[depth_used]   = k;
        value_mem[depth_used] = v;
        depth_used++;
        r.status = ST_PUSHED;
      end
    end else begin
      if (depth_used == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        depth_used--;
        r.key    = key_mem[depth_used];
        r.value  = value_mem[depth_used];
        r.status = ST_POPPED;
      end
    end
    r.fill = depth_used[FILL_W-1:0];
    return r;
  endfunction

  // Count a failure; print only the first few
  function automatic void note_failure(string what);
    mismatch_total++;
    if (mismatch_total <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
  endfunction

  // Check each response transaction, then record the request transaction of this edge
  always @(posedge clk) begin : track
    stack_reply_t want;
    if (rst) begin
      reply_q.delete();
      depth_used = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (reply_q.size() == 0) begin
          note_failure($sformatf("unexpected response: status %0d key %h value %h fill %0d",
                                 rsp.status, rsp.out_key, rsp.out_value, rsp.fill_count));
        end else begin
          want = reply_q.pop_front();
          if (rsp.status !== want.status || rsp.out_key !== want.key ||
              rsp.out_value !== want.value || rsp.fill_count !== want.fill) begin
            note_failure($sformatf({"status exp %0d got %0d, key exp %h got %h, ",
                                    "value exp %h got %h, fill exp %0d got %0d"},
                                   want.status, rsp.status, want.key, rsp.out_key,
                                   want.value, rsp.out_value, want.fill, rsp.fill_count));
          end
        end
      end
      if (req.valid && req.ready) begin
        reply_q.push_back(predict_stack_reply(req.cmd, req.in_key, req.in_value));
      end
    end
    replies_due <= reply_q.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
// Top of the unique key stack testbench: clock, reset, stimulus, response sink and verdict.
`timescale 1ns / 100ps

module tb;
  import uks_pkg::*;

  localparam int STACK_DEPTH      = STACK_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES      = 40;
  localparam int RANDOM_PHASES    = 27;
  localparam int PHASE_ITEMS      = 50;

  logic clk = 1'b0;
  logic rst;

  // Shared pacing controls, written by the stimulus only
  bit idle_on;
  int long_hold_ask;

  int monitor_fails;
  int replies_due;

  uks_req_if req_ch ();
  uks_rsp_if rsp_ch ();

  unique_key_stack_unit #(
    .STACK_DEPTH (STACK_DEPTH)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  uks_stack_monitor #(
    .STACK_DEPTH (STACK_DEPTH)
  ) stack_monitor (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (monitor_fails),
    .replies_due (replies_due)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one request, after a random gap when idle pacing is on, and hold it until it is accepted
  task automatic offer_request(input logic op, input logic [KEY_W-1:0] k,
                               input logic [VALUE_W-1:0] v);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.cmd      <= op;
    req_ch.in_key   <= k;
    req_ch.in_value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted response has been seen
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
  endtask

  // Keys: half from a small signed pool so duplicates are common, plus extremes and full range
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 3))
      0, 1: k = int'($urandom_range(0, 23)) - 12;
      2: begin
        case ($urandom_range(0, 3))
          0: k = 32'h8000_0000;
          1: k = 32'h7FFF_FFFF;
          2: k = 32'h0000_0000;
          default: k = 32'hFFFF_FFFF;
        endcase
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Response sink: random stalls, with a long hold-off whenever the stimulus asks for one
  initial begin : response_sink
    int stall;
    int long_hold_done;
    long_hold_done = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_ask > long_hold_done) begin
        stall = LONG_HOLD_CYCLES;
        long_hold_done++;
      end else begin
        stall = idle_on ? $urandom_range(0, 9) : 0;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  // End the run when no transaction completes for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("** unique_key_stack_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int push_pct;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.cmd      <= CMD_PUSH;
    req_ch.in_key   <= '0;
    req_ch.in_value <= '0;
    idle_on       = 1'b1;
    long_hold_ask = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: underflow, signed extremes, duplicate, fill to full, overflow,
    // duplicate into a full stack, pop with nonzero ignored payload
    offer_request(CMD_POP,  32'h0000_0000, 32'h0000_0000);
    offer_request(CMD_PUSH, 32'h8000_0000, 32'h7FFF_FFFF);
    offer_request(CMD_PUSH, 32'h7FFF_FFFF, 32'h8000_0000);
    offer_request(CMD_PUSH, 32'h8000_0000, 32'h1234_5678);
    offer_request(CMD_PUSH, 32'h0000_0000, 32'hFFFF_FFFF);
    offer_request(CMD_PUSH, 32'hFFFF_FFFF, 32'h0000_0000);
    offer_request(CMD_POP,  32'h0000_0000, 32'h0000_0000);
    for (int i = 1; i <= STACK_DEPTH - 3; i++) begin
      offer_request(CMD_PUSH, 32'h0000_0100 + i, $urandom);
    end
    offer_request(CMD_PUSH, 32'h5555_AAAA, 32'h0F0F_F0F0);
    offer_request(CMD_PUSH, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    offer_request(CMD_POP,  32'hA5A5_5A5A, 32'h5A5A_A5A5);
    drain_responses();

    // Random phases with changing push mix and pacing
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_on = (phase % 3 != 2);
      if (phase == 0) push_pct = 95;
      else if (phase == 1) push_pct = 20;
      else begin
        case ($urandom_range(0, 3))
          0: push_pct = 25;
          1: push_pct = 50;
          2: push_pct = 75;
          default: push_pct = 95;
        endcase
      end
      // stall the sink for a long stretch while requests keep coming
      if (phase == 4 || phase == 17) long_hold_ask++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(1, 100) <= push_pct) offer_request(CMD_PUSH, pick_key(), pick_value());
        else offer_request(CMD_POP, $urandom, $urandom);
      end
      if (phase % 4 == 3) drain_responses();
    end

    drain_responses();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (monitor_fails == 0 && replies_due == 0) begin
      $display("** unique_key_stack_unit: PASSED **");
    end else begin
      $display("** unique_key_stack_unit: FAILED **");
    end
    $finish;
  end

endmodule
